// ===== rtl/sbda_pkg.sv =====
// Shared constants and helpers for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps

package sbda_pkg;

  // Number width; bit VALUE_WIDTH-1 of {value_high, value_low} is the sign.
  localparam int VALUE_WIDTH = 128;

  // Decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude (log10(2) ~ 0.30103).
  localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int STEP_W = $clog2(VALUE_WIDTH + 1);
  localparam int DCNT_W = $clog2(DIGITS + 1);

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // Double-dabble correction: every BCD digit of 5 or more gets 3 added.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    r = b;
    for (int i = 0; i < DIGITS; i++) begin
      d = b[4*i +: 4];
      r[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sbda_if.sv =====
// Valid/ready channel interfaces for the number input and the character output.
`timescale 1ns / 1ps

interface sbda_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value_high;
  logic        [63:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface sbda_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII converter: one number in, its decimal text out.
//
// Channels: din takes one signed number as value_high (signed, sign included)
// and value_low; dout gives one ASCII character per transaction, a leading '-'
// for negative numbers, then the digits with no leading zeros, last set on the
// final character. Zero gives the single character '0'. The most negative
// value prints as its full magnitude 2^(VALUE_WIDTH-1).
// Sequence: one accept step, VALUE_WIDTH shift-and-adjust steps of the BCD
// unit (double dabble), then one step per skipped leading zero digit, one
// step to leave the zero skip and one step per emitted character, each
// emitted character waiting while the receiver stalls. din.ready is high
// only while idle.
// The output register lets the next number be accepted while the final
// character still waits. When the receiver stalls, the character holds and the
// sequencer waits. Reset (rst, synchronous) returns to idle with dout empty.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii
  import sbda_pkg::*;
(
  input logic        clk,
  input logic        rst,
  sbda_in_if.sink    din,
  sbda_out_if.source dout
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]             state, state_next;
  logic [VALUE_WIDTH-1:0] mag, mag_next;
  logic                   neg, neg_next;
  logic [BCD_W-1:0]       bcd, bcd_next;
  logic [STEP_W-1:0]      step, step_next;
  logic [DCNT_W-1:0]      remain, remain_next;
  logic                   ovalid, ovalid_next;
  logic [6:0]             ochar, ochar_next;
  logic                   olast, olast_next;

  logic [127:0]           full;
  logic [VALUE_WIDTH-1:0] val;
  logic                   sign;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [BCD_W-1:0]       bcd_adj;
  logic [3:0]             top;
  logic                   out_load;
  logic                   last_digit;

  assign full     = {din.value_high, din.value_low};
  assign val      = full[VALUE_WIDTH-1:0];
  assign sign     = val[VALUE_WIDTH-1];
  assign mag_in   = sign ? (~val + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : val;
  assign bcd_adj  = bcd_adjust(bcd);
  assign top      = bcd[BCD_W-1 -: 4];
  assign out_load = !ovalid || dout.ready;
  assign last_digit = (remain == DCNT_W'(1));

  assign din.ready      = (state == S_IDLE);
  assign dout.valid     = ovalid;
  assign dout.character = ochar;
  assign dout.last      = olast;

  always_comb begin
    state_next  = state;
    mag_next    = mag;
    neg_next    = neg;
    bcd_next    = bcd;
    step_next   = step;
    remain_next = remain;
    ovalid_next = ovalid;
    ochar_next  = ochar;
    olast_next  = olast;

    if (ovalid && dout.ready) begin
      ovalid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (din.valid) begin
          mag_next   = mag_in;
          neg_next   = sign;
          bcd_next   = '0;
          step_next  = '0;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        bcd_next  = {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
        mag_next  = mag << 1;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(VALUE_WIDTH - 1)) begin
          remain_next = DCNT_W'(DIGITS);
          state_next  = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, always keep the units digit
        if (top == 4'd0 && !last_digit) begin
          bcd_next    = bcd << 4;
          remain_next = remain - DCNT_W'(1);
        end else begin
          state_next = neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_load) begin
          ovalid_next = 1'b1;
          ochar_next  = CHAR_MINUS;
          olast_next  = 1'b0;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          ovalid_next = 1'b1;
          ochar_next  = CHAR_ZERO + {3'b000, top};
          olast_next  = last_digit;
          bcd_next    = bcd << 4;
          remain_next = remain - DCNT_W'(1);
          if (last_digit) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      step   <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
      step   <= step_next;
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    mag   <= mag_next;
    neg   <= neg_next;
    bcd   <= bcd_next;
    ochar <= ochar_next;
    olast <= olast_next;
  end

endmodule

// ===== rtl/sbda_checker.sv =====
// Port-level assertions for the decimal ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module sbda_checker
  import sbda_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] character,
  input logic       last
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output changed while stalled");

  // one number at a time: busy right after a transaction on din
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while converting");

  // when idle, only the final character of a number can still be pending
  a_idle_pending_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last)
    else $error("idle with a non-final character pending");

  // only '-' or digits, and a sign is never the final character
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS && !last) ||
                  (character >= CHAR_ZERO && character <= CHAR_ZERO + 7'd9))
    else $error("illegal character");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .character (dout.character),
  .last      (dout.last)
);
